FILE: hdl/dmip_pkg.sv
// Shared types and constants for the dual motor incremental PID block.
package dmip_pkg;

   // Fixed field and register widths.
   localparam int GAIN_W     = 24;
   localparam int ACC_W      = 32;
   localparam int DUTY_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int RSP_DATA_W = 32;

   // Duty clamp and the accumulator's reset value in whole units.
   localparam int DUTY_MAX    = 99;
   localparam int ACC_RESET_INT = 10;

   // Gain register reset values.
   localparam logic [GAIN_W-1:0] PROP_GAIN_RESET  = 24'd655360;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RESET = 24'd262;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RESET = 24'd0;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_LEFT,
      REG_INTEG_LEFT,
      REG_DERIV_LEFT,
      REG_PROP_RIGHT,
      REG_INTEG_RIGHT,
      REG_DERIV_RIGHT,
      REG_COAST_MODE
   } csr_index_type;

   // Gains of one lane.
   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } lane_gain_type;

   // Stage advance strobes shared by both lanes.
   typedef struct packed {
      logic load_err;
      logic load_prod;
      logic load_delta;
      logic load_acc;
   } lane_adv_type;

endpackage

FILE: hdl/dmip_lane.sv
// One motor lane: error history, three gain products, sum and saturating accumulator.
module dmip_lane #(
   parameter int SPEED_BITS     = 12,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dmip_pkg::lane_adv_type                 adv,
   input  dmip_pkg::lane_gain_type                gain,
   input  logic                                   coast_mode,
   input  logic [SPEED_BITS-2:0]                  target,
   input  logic signed [SPEED_BITS-1:0]           measured,
   output logic signed [dmip_pkg::ACC_W-1:0]      acc
);

   localparam int ERR_W   = SPEED_BITS + 1;
   localparam int D1_W    = ERR_W + 1;
   localparam int D2_W    = ERR_W + 2;
   localparam int IG_W    = dmip_pkg::GAIN_W + 5;
   localparam int PP_W    = dmip_pkg::GAIN_W + 1 + D1_W;
   localparam int PI_W    = IG_W + 1 + ERR_W;
   localparam int PD_W    = dmip_pkg::GAIN_W + 1 + D2_W;
   localparam int SUM_W   = PI_W + 2;
   localparam int ASUM_W  = SUM_W + 1;
   localparam int ACC_W   = dmip_pkg::ACC_W;
   localparam logic signed [ACC_W-1:0] ACC_RESET =
      ACC_W'(dmip_pkg::ACC_RESET_INT) << GAIN_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic signed [ERR_W-1:0]  err_in;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [ERR_W-1:0]  err1_ff;
   logic signed [ERR_W-1:0]  err2_ff;
   logic signed [D1_W-1:0]   d1_in;
   logic signed [D1_W-1:0]   d1_ff;
   logic signed [D2_W-1:0]   d2_in;
   logic signed [D2_W-1:0]   d2_ff;
   logic [IG_W-1:0]          integ_eff;
   logic signed [PP_W-1:0]   pp_in;
   logic signed [PP_W-1:0]   pp_ff;
   logic signed [PI_W-1:0]   pi_in;
   logic signed [PI_W-1:0]   pi_ff;
   logic signed [PD_W-1:0]   pd_in;
   logic signed [PD_W-1:0]   pd_ff;
   logic signed [SUM_W-1:0]  delta_in;
   logic signed [SUM_W-1:0]  delta_ff;
   logic signed [ASUM_W-1:0] acc_sum;
   logic [ASUM_W-ACC_W:0]    acc_hi;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;

   // Error and its first and second differences against the stored history.
   always_comb begin
      err_in = $signed({2'b00, target}) - $signed({measured[SPEED_BITS-1], measured});
      d1_in  = D1_W'(err_in) - D1_W'(err1_ff);
      d2_in  = D2_W'(err_in) - (D2_W'(err1_ff) <<< 1) + D2_W'(err2_ff);
   end

   // The error history moves on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         err1_ff <= '0;
         err2_ff <= '0;
      end else if (adv.load_err) begin
         err1_ff <= err_in;
         err2_ff <= err1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv.load_err) begin
         err_ff <= err_in;
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
      end
   end

   // Coast mode scales the integral gain by twenty as 16x + 4x.
   always_comb begin
      if (coast_mode) begin
         integ_eff = (IG_W'(gain.integ) << 4) + (IG_W'(gain.integ) << 2);
      end else begin
         integ_eff = IG_W'(gain.integ);
      end
   end

   // Three gain products, each registered.
   always_comb begin
      pp_in = $signed({1'b0, gain.prop}) * d1_ff;
      pi_in = $signed({1'b0, integ_eff}) * err_ff;
      pd_in = $signed({1'b0, gain.deriv}) * d2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv.load_prod) begin
         pp_ff <= pp_in;
         pi_ff <= pi_in;
         pd_ff <= pd_in;
      end
   end

   // Exact increment of the accumulator.
   assign delta_in = SUM_W'(pp_ff) + SUM_W'(pi_ff) + SUM_W'(pd_ff);

   always_ff @(posedge clock) begin
      if (adv.load_delta) begin
         delta_ff <= delta_in;
      end
   end

   // Accumulate and saturate to the signed 32-bit range.
   always_comb begin
      acc_sum = ASUM_W'(acc_ff) + ASUM_W'(delta_ff);
      acc_hi  = acc_sum[ASUM_W-1:ACC_W-1];
      if ((&acc_hi) || !(|acc_hi)) begin
         acc_in = acc_sum[ACC_W-1:0];
      end else if (acc_sum[ASUM_W-1]) begin
         acc_in = ACC_MIN;
      end else begin
         acc_in = ACC_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= ACC_RESET;
      end else if (adv.load_acc) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: hdl/dmip_merge.sv
// Merge stage: turns both lane accumulators into forward and reverse duties.
module dmip_merge #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic signed [dmip_pkg::ACC_W-1:0]  acc_left,
   input  logic signed [dmip_pkg::ACC_W-1:0]  acc_right,
   output logic [dmip_pkg::DUTY_W-1:0]        forward_duty_left,
   output logic [dmip_pkg::DUTY_W-1:0]        reverse_duty_left,
   output logic [dmip_pkg::DUTY_W-1:0]        forward_duty_right,
   output logic [dmip_pkg::DUTY_W-1:0]        reverse_duty_right
);

   localparam int ACC_W  = dmip_pkg::ACC_W;
   localparam int MAG_W  = ACC_W + 1;
   localparam int DUTY_W = dmip_pkg::DUTY_W;

   logic [DUTY_W-1:0] fwd_left_ff;
   logic [DUTY_W-1:0] rev_left_ff;
   logic [DUTY_W-1:0] fwd_right_ff;
   logic [DUTY_W-1:0] rev_right_ff;

   // Halve the magnitude, drop the fraction and clamp to the duty limit.
   function automatic logic [DUTY_W-1:0] clamp_duty(input logic [MAG_W-1:0] mag);
      logic [MAG_W-1:0] whole;
      whole = mag >> (GAIN_FRAC_BITS + 1);
      if (whole > MAG_W'(dmip_pkg::DUTY_MAX)) begin
         return DUTY_W'(dmip_pkg::DUTY_MAX);
      end
      return whole[DUTY_W-1:0];
   endfunction

   // A positive accumulator drives forward; zero or negative drives reverse.
   function automatic logic [DUTY_W-1:0] fwd_duty(input logic signed [ACC_W-1:0] a);
      if (!a[ACC_W-1] && (a != '0)) begin
         return clamp_duty({1'b0, a});
      end
      return '0;
   endfunction

   function automatic logic [DUTY_W-1:0] rev_duty(input logic signed [ACC_W-1:0] a);
      logic [MAG_W-1:0] mag;
      mag = -{a[ACC_W-1], a};
      if (!a[ACC_W-1] && (a != '0)) begin
         return '0;
      end
      return clamp_duty(mag);
   endfunction

   // Output register of the result channel.
   always_ff @(posedge clock) begin
      if (load) begin
         fwd_left_ff  <= fwd_duty(acc_left);
         rev_left_ff  <= rev_duty(acc_left);
         fwd_right_ff <= fwd_duty(acc_right);
         rev_right_ff <= rev_duty(acc_right);
      end
   end

   assign forward_duty_left  = fwd_left_ff;
   assign reverse_duty_left  = rev_left_ff;
   assign forward_duty_right = fwd_right_ff;
   assign reverse_duty_right = rev_right_ff;

endmodule

FILE: hdl/dual_motor_incremental_pid.sv
// Top level of the dual motor incremental PID: channels, registers, pipeline control.
// A result passes the error, product, increment, accumulator and output registers.
// One item per cycle unless the output stalls; the accumulate-and-saturate loop sets it.
// Each stage advances into a free slot; a waiting result blocks new input only once all
// five stages are full. Reset (synchronous, active high) restores default gains, clears
// coast mode and the error history, sets both accumulators to ten and empties the pipeline.
module dual_motor_incremental_pid #(
   parameter int SPEED_BITS     = 12,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // target_left, target_right, measured_left, measured_right, zero fill
   input  logic [((4*SPEED_BITS-2+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // forward_duty_left, reverse_duty_left, forward_duty_right, reverse_duty_right, zero fill
   output logic [dmip_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_we,
   input  logic [dmip_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dmip_pkg::GAIN_W-1:0]       csr_wdata
);

   localparam int TGT_W  = SPEED_BITS - 1;
   localparam int DUTY_W = dmip_pkg::DUTY_W;
   localparam int ACC_W  = dmip_pkg::ACC_W;

   dmip_pkg::lane_gain_type gain_left_ff;
   dmip_pkg::lane_gain_type gain_right_ff;
   logic                    coast_ff;
   dmip_pkg::lane_adv_type  adv;
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                    rdy1, rdy2, rdy3, rdy4, rdy5;
   logic                    load_out;
   logic [TGT_W-1:0]        target_left;
   logic [TGT_W-1:0]        target_right;
   logic signed [SPEED_BITS-1:0] measured_left;
   logic signed [SPEED_BITS-1:0] measured_right;
   logic signed [ACC_W-1:0] acc_left;
   logic signed [ACC_W-1:0] acc_right;
   logic [DUTY_W-1:0]       forward_duty_left;
   logic [DUTY_W-1:0]       reverse_duty_left;
   logic [DUTY_W-1:0]       forward_duty_right;
   logic [DUTY_W-1:0]       reverse_duty_right;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_left_ff  <= '{dmip_pkg::PROP_GAIN_RESET, dmip_pkg::INTEG_GAIN_RESET,
                            dmip_pkg::DERIV_GAIN_RESET};
         gain_right_ff <= '{dmip_pkg::PROP_GAIN_RESET, dmip_pkg::INTEG_GAIN_RESET,
                            dmip_pkg::DERIV_GAIN_RESET};
         coast_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            dmip_pkg::REG_PROP_LEFT:   gain_left_ff.prop   <= csr_wdata;
            dmip_pkg::REG_INTEG_LEFT:  gain_left_ff.integ  <= csr_wdata;
            dmip_pkg::REG_DERIV_LEFT:  gain_left_ff.deriv  <= csr_wdata;
            dmip_pkg::REG_PROP_RIGHT:  gain_right_ff.prop  <= csr_wdata;
            dmip_pkg::REG_INTEG_RIGHT: gain_right_ff.integ <= csr_wdata;
            dmip_pkg::REG_DERIV_RIGHT: gain_right_ff.deriv <= csr_wdata;
            dmip_pkg::REG_COAST_MODE:  coast_ff            <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input field unpacking.
   assign target_left    = req_tdata[TGT_W-1:0];
   assign target_right   = req_tdata[2*TGT_W-1:TGT_W];
   assign measured_left  = req_tdata[2*TGT_W+SPEED_BITS-1:2*TGT_W];
   assign measured_right = req_tdata[2*TGT_W+2*SPEED_BITS-1:2*TGT_W+SPEED_BITS];

   // Each stage takes a new item when it is empty or its item moves on.
   always_comb begin
      rdy5 = !v5_ff || rsp_tready;
      rdy4 = !v4_ff || rdy5;
      rdy3 = !v3_ff || rdy4;
      rdy2 = !v2_ff || rdy3;
      rdy1 = !v1_ff || rdy2;
      adv.load_err   = req_tvalid && rdy1;
      adv.load_prod  = v1_ff && rdy2;
      adv.load_delta = v2_ff && rdy3;
      adv.load_acc   = v3_ff && rdy4;
      load_out       = v4_ff && rdy5;
   end

   assign req_tready = rdy1;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Two lanes side by side.
   dmip_lane #(
      .SPEED_BITS     (SPEED_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .gain       (gain_left_ff),
      .coast_mode (coast_ff),
      .target     (target_left),
      .measured   (measured_left),
      .acc        (acc_left)
   );

   dmip_lane #(
      .SPEED_BITS     (SPEED_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .gain       (gain_right_ff),
      .coast_mode (coast_ff),
      .target     (target_right),
      .measured   (measured_right),
      .acc        (acc_right)
   );

   // Duty conversion and output register.
   dmip_merge #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_merge (
      .clock              (clock),
      .load               (load_out),
      .acc_left           (acc_left),
      .acc_right          (acc_right),
      .forward_duty_left  (forward_duty_left),
      .reverse_duty_left  (reverse_duty_left),
      .forward_duty_right (forward_duty_right),
      .reverse_duty_right (reverse_duty_right)
   );

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {(dmip_pkg::RSP_DATA_W - 4*DUTY_W)'(0),
                        reverse_duty_right, forward_duty_right,
                        reverse_duty_left, forward_duty_left};

   // An accepted transfer always lands in the first stage.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted item did not enter the pipeline");

   // With every stage full and the output stalled, no input is taken.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while the pipeline is full");

   // Only one direction of a motor is driven at a time.
   a_one_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((forward_duty_left == '0 || reverse_duty_left == '0) &&
                      (forward_duty_right == '0 || reverse_duty_right == '0)))
      else $error("forward and reverse duty both active");

   // Duties never exceed the clamp.
   a_duty_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (forward_duty_left <= DUTY_W'(dmip_pkg::DUTY_MAX) &&
                      reverse_duty_left <= DUTY_W'(dmip_pkg::DUTY_MAX) &&
                      forward_duty_right <= DUTY_W'(dmip_pkg::DUTY_MAX) &&
                      reverse_duty_right <= DUTY_W'(dmip_pkg::DUTY_MAX)))
      else $error("duty above the clamp");

endmodule
